FILE: src/mmel_pkg.sv
`default_nettype none

package mmel_pkg;

	// shape of one triangle: an edge lane for each edge, and x, y, z axes for each vertex
	localparam int NUM_LANES = 3;
	localparam int NUM_AXES  = 3;

	// squared lengths never go past this many bits, larger sums saturate
	localparam int SQ_CAP = 64;

	// result field
	localparam int                   OUT_WIDTH = 25;
	localparam logic [OUT_WIDTH-1:0] OUT_MAX   = {OUT_WIDTH{1'b1}};

	// status of the root unit as seen by the control logic
	typedef struct packed {
		logic busy;
		logic done;
	} mmel_sqrt_stat_t;

endpackage

`default_nettype wire

FILE: src/mmel_tri_if.sv
`default_nettype none

interface mmel_tri_if #(
	parameter int COORD_WIDTH = 24
) ();
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] ax;
	logic signed [COORD_WIDTH-1:0] ay;
	logic signed [COORD_WIDTH-1:0] az;
	logic signed [COORD_WIDTH-1:0] bx;
	logic signed [COORD_WIDTH-1:0] by_coord;
	logic signed [COORD_WIDTH-1:0] bz;
	logic signed [COORD_WIDTH-1:0] cx;
	logic signed [COORD_WIDTH-1:0] cy;
	logic signed [COORD_WIDTH-1:0] cz;
	logic                          last_triangle;

	modport source (
		output valid, ax, ay, az, bx, by_coord, bz, cx, cy, cz, last_triangle,
		input  ready
	);

	modport sink (
		input  valid, ax, ay, az, bx, by_coord, bz, cx, cy, cz, last_triangle,
		output ready
	);
endinterface

`default_nettype wire

FILE: src/mmel_len_if.sv
`default_nettype none

interface mmel_len_if
	import mmel_pkg::*;
();
	logic                 valid;
	logic                 ready;
	logic [OUT_WIDTH-1:0] min_edge;

	modport source (
		output valid, min_edge,
		input  ready
	);

	modport sink (
		input  valid, min_edge,
		output ready
	);
endinterface

`default_nettype wire

FILE: src/mesh_min_edge_length.sv
// channel    | dir | modport              | request carries
// -----------+-----+----------------------+--------------------------------------
// triangle   | in  | mmel_tri_if.sink     | vertices a, b, c (Q12.12), last_triangle
// result     | out | mmel_len_if.source   | min_edge, floor root of the mesh minimum
//
// within a mesh one triangle is taken every cycle; an edge lane runs five stages
// (difference, square, partial sum, clamp, lane merge) before the running minimum
// the last triangle of a mesh starts the root unit for an RW = MW/2 bit root
// (25 at the default width); a further last triangle waits until that root is out
// and taken, while ordinary triangles of the next mesh keep flowing
// arst_n clears the stage valids, the running minimum (to all ones), the root unit
// and the result request; a stalled result holds only the next last triangle
`default_nettype none

module mesh_min_edge_length
	import mmel_pkg::*;
#(
	parameter int COORD_WIDTH = 24
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	mmel_tri_if.sink   triangle,
	mmel_len_if.source result
);

	localparam int CW = COORD_WIDTH;
	localparam int SW = 2 * CW + 2;
	localparam int MW = (SW > SQ_CAP) ? SQ_CAP : SW;

	// vertex table: vtx[v][axis]
	logic signed [CW-1:0] vtx [NUM_LANES][NUM_AXES];
	logic [MW-1:0]        lane_len [NUM_LANES];
	logic [MW-1:0]        tri_min;

	// stage valids and last marks, one per lane stage plus the merge stage
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic lst_s1, lst_s2, lst_s3, lst_s4, lst_s5;

	logic                 accept;
	logic                 last_busy;
	logic [MW-1:0]        min_q;
	logic [MW-1:0]        new_min;
	logic                 sqrt_start;
	mmel_sqrt_stat_t      sqrt_stat;
	logic [OUT_WIDTH-1:0] sqrt_root;
	logic                 out_valid_q;
	logic [OUT_WIDTH-1:0] min_edge_q;

	assign vtx[0] = '{triangle.ax, triangle.ay, triangle.az};
	assign vtx[1] = '{triangle.bx, triangle.by_coord, triangle.bz};
	assign vtx[2] = '{triangle.cx, triangle.cy, triangle.cz};

	// a last triangle may only enter when nothing else needs the root unit
	// or the result register; ordinary triangles never need them
	assign last_busy = lst_s1 | lst_s2 | lst_s3 | lst_s4 | lst_s5
		| sqrt_stat.busy | out_valid_q;
	assign triangle.ready = !last_busy || !triangle.last_triangle;
	assign accept         = triangle.valid && triangle.ready;

	// edge lanes: ab, bc, ca
	generate
		for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
			mmel_edge_lane #(
				.CW(CW)
			) u_lane (
				.clk   (clk),
				.p     (vtx[l]),
				.q     (vtx[(l + 1) % NUM_LANES]),
				.sq_len(lane_len[l])
			);
		end
	endgenerate

	mmel_lane_merge #(
		.MW(MW)
	) u_merge (
		.clk     (clk),
		.lane_len(lane_len),
		.min_len (tri_min)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			lst_s1 <= 1'b0;
			lst_s2 <= 1'b0;
			lst_s3 <= 1'b0;
			lst_s4 <= 1'b0;
			lst_s5 <= 1'b0;
		end else begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			lst_s1 <= accept && triangle.last_triangle;
			lst_s2 <= lst_s1;
			lst_s3 <= lst_s2;
			lst_s4 <= lst_s3;
			lst_s5 <= lst_s4;
		end
	end

	// running minimum; a last triangle folds in its own edges first
	assign new_min    = (tri_min < min_q) ? tri_min : min_q;
	assign sqrt_start = vld_s5 && lst_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= {MW{1'b1}};
		end else if (vld_s5) begin
			min_q <= lst_s5 ? {MW{1'b1}} : new_min;
		end
	end

	mmel_sqrt #(
		.MW(MW)
	) u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (sqrt_start),
		.radicand(new_min),
		.stat    (sqrt_stat),
		.root    (sqrt_root)
	);

	// result register, loaded as the root unit finishes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (sqrt_stat.done) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sqrt_stat.done) begin
			min_edge_q <= sqrt_root;
		end
	end

	assign result.valid    = out_valid_q;
	assign result.min_edge = min_edge_q;

endmodule

`default_nettype wire

FILE: src/mmel_edge_lane.sv
`default_nettype none

module mmel_edge_lane
	import mmel_pkg::*;
#(
	parameter int CW = 24
) (
	input  wire logic                 clk,
	input  wire logic signed [CW-1:0] p [NUM_AXES],
	input  wire logic signed [CW-1:0] q [NUM_AXES],
	output logic [((2*CW+2) > SQ_CAP ? SQ_CAP : (2*CW+2))-1:0] sq_len
);

	localparam int SQW = 2 * CW;
	localparam int SW  = 2 * CW + 2;
	localparam int MW  = (SW > SQ_CAP) ? SQ_CAP : SW;

	logic [CW-1:0]  mag_d  [NUM_AXES];
	logic [CW-1:0]  mag_s1 [NUM_AXES];
	logic [SQW-1:0] sq_s2  [NUM_AXES];
	logic [SQW:0]   part_s3;
	logic [SQW-1:0] sq2_s3;
	logic [SW-1:0]  sum;
	logic [MW-1:0]  len_s4;

	// absolute difference per axis, both directions in parallel
	always_comb begin
		logic signed [CW:0] pq;
		logic signed [CW:0] qp;
		for (int i = 0; i < NUM_AXES; i++) begin
			pq = {p[i][CW-1], p[i]} - {q[i][CW-1], q[i]};
			qp = {q[i][CW-1], q[i]} - {p[i][CW-1], p[i]};
			mag_d[i] = pq[CW] ? qp[CW-1:0] : pq[CW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < NUM_AXES; i++) begin
			mag_s1[i] <= mag_d[i];
			sq_s2[i]  <= mag_s1[i] * mag_s1[i];
		end
		part_s3 <= {1'b0, sq_s2[0]} + {1'b0, sq_s2[1]};
		sq2_s3  <= sq_s2[2];
	end

	assign sum = {1'b0, part_s3} + {2'b00, sq2_s3};

	// clamp sums that do not fit the squared-length register
	generate
		if (SW > MW) begin : g_sat
			always_ff @(posedge clk) begin
				len_s4 <= (|sum[SW-1:MW]) ? {MW{1'b1}} : sum[MW-1:0];
			end
		end else begin : g_nosat
			always_ff @(posedge clk) begin
				len_s4 <= sum[MW-1:0];
			end
		end
	endgenerate

	assign sq_len = len_s4;

endmodule

`default_nettype wire

FILE: src/mmel_lane_merge.sv
`default_nettype none

module mmel_lane_merge
	import mmel_pkg::*;
#(
	parameter int MW = 50
) (
	input  wire logic          clk,
	input  wire logic [MW-1:0] lane_len [NUM_LANES],
	output logic [MW-1:0]      min_len
);

	logic [MW-1:0] min_d;
	logic [MW-1:0] min_s5;

	always_comb begin
		min_d = lane_len[0];
		for (int i = 1; i < NUM_LANES; i++) begin
			if (lane_len[i] < min_d) begin
				min_d = lane_len[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		min_s5 <= min_d;
	end

	assign min_len = min_s5;

endmodule

`default_nettype wire

FILE: src/mmel_sqrt.sv
`default_nettype none

module mmel_sqrt
	import mmel_pkg::*;
#(
	parameter int MW = 50
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic [MW-1:0]        radicand,
	output mmel_sqrt_stat_t           stat,
	output logic [OUT_WIDTH-1:0]      root
);

	localparam int RW = MW / 2;
	localparam int CNTW = $clog2(RW);
	localparam int EW = (RW > OUT_WIDTH) ? RW : OUT_WIDTH;

	logic            busy_q;
	logic [CNTW-1:0] cnt_q;
	logic [MW-1:0]   rad_q;
	logic [RW+1:0]   rem_q;
	logic [RW-1:0]   root_q;
	logic [RW+1:0]   rem_sh;
	logic [RW+1:0]   trial;
	logic            ge;
	logic            last_step;
	logic [EW-1:0]   root_ext;

	// restoring digit recurrence, one result bit per cycle
	assign rem_sh    = {rem_q[RW-1:0], rad_q[MW-1 -: 2]};
	assign trial     = {root_q, 2'b01};
	assign ge        = (rem_sh >= trial);
	assign last_step = busy_q && (cnt_q == CNTW'(RW - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			busy_q <= !last_step;
			cnt_q  <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[MW-3:0], 2'b00};
			rem_q  <= ge ? (rem_sh - trial) : rem_sh;
			root_q <= {root_q[RW-2:0], ge};
		end
	end

	// the root is valid while the last step is taken, its final bit formed combinationally
	always_comb begin
		root_ext = EW'({root_q[RW-2:0], ge});
		if (root_ext > EW'(OUT_MAX)) begin
			root = OUT_MAX;
		end else begin
			root = root_ext[OUT_WIDTH-1:0];
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = last_step;

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import mmel_pkg::*;

	localparam int CW           = 24;
	localparam int SQ_W         = 2*CW + 2;
	localparam int RANDOM_ITEMS = 600;
	localparam int TIMEOUT_NS   = 10_000_000;
	localparam int LO           = -(1 << (CW-1));
	localparam int HI           = (1 << (CW-1)) - 1;

	typedef logic signed [CW-1:0] coord_t;
	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
	} vert_t;
	typedef struct packed {
		vert_t a;
		vert_t b;
		vert_t c;
		logic  closes_mesh;
	} tri_t;
	typedef logic [OUT_WIDTH-1:0] len_t;

	// running mesh minimum plus the lengths still owed by the block
	class min_edge_tracker;
		logic [SQ_W-1:0] run_min;
		len_t            expected_lengths[$];
		int              triangles;
		int              meshes;
		int              checked;
		int              mismatches;

		function new();
			run_min    = '1;
			triangles  = 0;
			meshes     = 0;
			checked    = 0;
			mismatches = 0;
		endfunction

		function logic [63:0] axis_sq(coord_t p, coord_t q);
			longint      d;
			logic [63:0] m;
			d = longint'(p) - longint'(q);
			m = (d < 0) ? -d : d;
			return m * m;
		endfunction

		function logic [63:0] sum_sat(logic [63:0] s, logic [63:0] v);
			logic [64:0] t;
			t = {1'b0, s} + {1'b0, v};
			return t[64] ? {64{1'b1}} : t[63:0];
		endfunction

		function logic [63:0] edge_sq(vert_t p, vert_t q);
			logic [63:0] s;
			s = axis_sq(p.x, q.x);
			s = sum_sat(s, axis_sq(p.y, q.y));
			s = sum_sat(s, axis_sq(p.z, q.z));
			return s;
		endfunction

		// bitwise floor root, clamped to the result width
		function len_t floor_root(logic [63:0] n);
			logic [63:0] root;
			logic [63:0] trial;
			root = '0;
			for (int i = 31; i >= 0; i--) begin
				trial = root | (64'd1 << i);
				if (trial * trial <= n)
					root = trial;
			end
			return (root > OUT_MAX) ? OUT_MAX : root[OUT_WIDTH-1:0];
		endfunction

		function void fold_triangle(tri_t t);
			logic [63:0] shortest;
			logic [63:0] e;
			shortest = edge_sq(t.a, t.b);
			e = edge_sq(t.b, t.c);
			if (e < shortest)
				shortest = e;
			e = edge_sq(t.c, t.a);
			if (e < shortest)
				shortest = e;
			if (shortest < run_min)
				run_min = shortest[SQ_W-1:0];
			triangles++;
			if (t.closes_mesh) begin
				expected_lengths = {expected_lengths, floor_root(64'(run_min))};
				run_min = '1;
				meshes++;
			end
		endfunction

		function void check_length(len_t got);
			len_t want;
			if (expected_lengths.size() == 0) begin
				mismatches++;
				$display("%0t: min_edge %0d arrived with no mesh outstanding", $time, got);
				return;
			end
			want = expected_lengths.pop_front();
			checked++;
			if (got !== want) begin
				mismatches++;
				$display("%0t: min_edge mismatch, expected %0d, actual %0d", $time, want, got);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit   steady;   // when set, neither side idles

	min_edge_tracker board = new();

	mmel_tri_if #(.COORD_WIDTH(CW)) tri_ch ();
	mmel_len_if                     len_ch ();

	mesh_min_edge_length #(
		.COORD_WIDTH(CW)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.triangle (tri_ch),
		.result   (len_ch)
	);

	// 12 ns clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// hard stop in case a request never completes
	initial begin
		#(TIMEOUT_NS);
		$display("tb_top failed");
		$finish;
	end

	// idle length: mostly none, some short, a few long
	function automatic int pick_idle();
		int r;
		r = $urandom_range(99);
		if (steady || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(6, 40);
	endfunction

	function automatic coord_t rand_coord();
		return coord_t'($urandom);
	endfunction

	// one of the two range ends or zero
	function automatic coord_t extreme_coord();
		case ($urandom_range(2))
			0:       return coord_t'(LO);
			1:       return coord_t'(HI);
			default: return '0;
		endcase
	endfunction

	// small random offset from p; wraps at the field width like any coordinate
	function automatic coord_t near(coord_t p, int span);
		return coord_t'(int'(p) + int'($urandom_range(2*span)) - span);
	endfunction

	function automatic tri_t mk(int ax, int ay, int az, int bx, int by, int bz,
			int cx, int cy, int cz, bit closes);
		tri_t t;
		t.a = '{coord_t'(ax), coord_t'(ay), coord_t'(az)};
		t.b = '{coord_t'(bx), coord_t'(by), coord_t'(bz)};
		t.c = '{coord_t'(cx), coord_t'(cy), coord_t'(cz)};
		t.closes_mesh = closes;
		return t;
	endfunction

	// full-range, clustered or corner triangles, now and then with two vertices equal
	function automatic tri_t random_triangle();
		tri_t t;
		int   mode;
		int   span;
		t    = '0;
		mode = $urandom_range(99);
		if (mode < 35) begin
			t.a = '{rand_coord(), rand_coord(), rand_coord()};
			t.b = '{rand_coord(), rand_coord(), rand_coord()};
			t.c = '{rand_coord(), rand_coord(), rand_coord()};
		end else if (mode < 80) begin
			span = 1 << $urandom_range(0, 14);
			t.a  = '{rand_coord(), rand_coord(), rand_coord()};
			t.b  = '{near(t.a.x, span), near(t.a.y, span), near(t.a.z, span)};
			t.c  = '{near(t.a.x, span), near(t.a.y, span), near(t.a.z, span)};
		end else begin
			t.a = '{extreme_coord(), extreme_coord(), extreme_coord()};
			t.b = '{extreme_coord(), extreme_coord(), extreme_coord()};
			t.c = '{extreme_coord(), extreme_coord(), extreme_coord()};
		end
		if ($urandom_range(11) == 0) begin
			case ($urandom_range(2))
				0:       t.b = t.a;
				1:       t.c = t.b;
				default: t.a = t.c;
			endcase
		end
		return t;
	endfunction

	task automatic put_triangle(tri_t t);
		tri_ch.ax            <= t.a.x;
		tri_ch.ay            <= t.a.y;
		tri_ch.az            <= t.a.z;
		tri_ch.bx            <= t.b.x;
		tri_ch.by_coord      <= t.b.y;
		tri_ch.bz            <= t.b.z;
		tri_ch.cx            <= t.c.x;
		tri_ch.cy            <= t.c.y;
		tri_ch.cz            <= t.c.z;
		tri_ch.last_triangle <= t.closes_mesh;
	endtask

	// drive on the falling edge, hold until accepted at a rising edge
	// valid gets at most one assignment per falling edge
	task automatic send_triangle(tri_t t, int gap);
		@(negedge clk);
		if (gap > 0) begin
			tri_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		tri_ch.valid <= 1'b1;
		put_triangle(t);
		do @(posedge clk); while (!tri_ch.ready);
		board.fold_triangle(t);
	endtask

	// hold the sender idle until every owed length has come back
	task automatic wait_drained();
		@(negedge clk);
		tri_ch.valid <= 1'b0;
		while (board.expected_lengths.size() != 0)
			@(posedge clk);
	endtask

	// result side: random back-pressure, changed on the falling edge
	initial begin
		int hold;
		hold         = 0;
		len_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				len_ch.ready <= 1'b0;
				hold--;
			end else begin
				len_ch.ready <= 1'b1;
				hold = pick_idle();
			end
		end
	end

	// every accepted length request is checked against the oldest owed value
	always @(posedge clk) begin
		if (arst_n && len_ch.valid && len_ch.ready)
			board.check_length(len_ch.min_edge);
	end

	initial begin
		tri_t directed[$];
		tri_t t;
		int   sent;
		int   n;
		bit   drained_mid;

		arst_n       = 1'b0;
		steady       = 1'b0;
		tri_ch.valid = 1'b0;
		put_triangle('0);
		sent         = 0;
		drained_mid  = 1'b0;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// single-triangle meshes at the origin and at the corners of the range
		directed = {directed, mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 1)};
		directed = {directed, mk(LO, LO, LO, HI, HI, HI, LO, LO, LO, 1)};
		// face diagonals of the full cube: the top result bit is set
		directed = {directed, mk(LO, LO, LO, HI, HI, LO, HI, LO, HI, 1)};
		directed = {directed, mk(LO, HI, LO, HI, LO, LO, LO, LO, HI, 1)};
		// shortest edge is AB of the first triangle, later ones are longer
		directed = {directed, mk(0, 0, 0, 4096, 0, 0, 0, 40960, 0, 0)};
		directed = {directed, mk(LO, 0, 0, 0, HI, 0, HI, HI, HI, 0)};
		directed = {directed, mk(-70000, 5, 5, 70000, 5, 5, 0, 90000, -3, 0)};
		directed = {directed, mk(1, 2, 3, 9001, 2, 3, 1, -8000, 3, 1)};
		// shortest edge is BC of the closing triangle
		directed = {directed, mk(HI, HI, HI, LO, LO, LO, 0, 0, 0, 0)};
		directed = {directed, mk(0, 0, 0, 100000, 0, 0, 100000, 3, 4, 1)};
		// shortest edge is CA
		directed = {directed, mk(-5, -5, -5, 1000, 1000, 1000, -5, -5, -4, 0)};
		directed = {directed, mk(LO, LO, HI, HI, HI, LO, 0, 0, 0, 1)};
		// degenerate triangle in the middle of a mesh forces zero
		directed = {directed, mk(300, 300, 300, 9000, 300, 300, 300, 9000, 300, 0)};
		directed = {directed, mk(-20, 7, LO, 500, 500, 500, 500, 500, 500, 0)};
		directed = {directed, mk(12, 12, 12, -4000, 0, 0, 0, 4000, 0, 1)};
		// root floors: sqrt(3) and sqrt(8)
		directed = {directed, mk(0, 0, 0, 1, 1, 1, -1, -1, -1, 1)};
		directed = {directed, mk(0, 0, 0, 2, 2, 0, LO, HI, LO, 1)};
		// minimum must start over after the previous small result
		directed = {directed, mk(0, 0, 0, 1000, 0, 0, 0, 3000, 0, 0)};
		directed = {directed, mk(7, 7, 7, 3007, 7, 7, 7, 3007, 7, 1)};

		foreach (directed[i])
			send_triangle(directed[i], pick_idle());
		wait_drained();

		// random meshes: mostly short, some long, some stretches with no idling
		while (sent < RANDOM_ITEMS) begin
			steady = ($urandom_range(5) == 0);
			n = ($urandom_range(9) < 8) ? $urandom_range(1, 6) : $urandom_range(7, 30);
			for (int i = 0; i < n; i++) begin
				t             = random_triangle();
				t.closes_mesh = (i == n - 1);
				send_triangle(t, pick_idle());
				sent++;
			end
			if (!drained_mid && sent >= RANDOM_ITEMS / 2) begin
				wait_drained();
				drained_mid = 1'b1;
			end
		end
		steady = 1'b0;
		@(negedge clk);
		tri_ch.valid <= 1'b0;

		// let the last root and any stray result come out
		wait_drained();
		repeat (60) @(posedge clk);

		$display("run covered %0d triangles in %0d meshes, directed corners, degenerate",
			board.triangles, board.meshes);
		$display("and clustered shapes; %0d lengths checked, %0d mismatches",
			board.checked, board.mismatches);
		if (board.mismatches == 0 && board.expected_lengths.size() == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule

FILE: mesh_min_edge_length.f
src/mmel_pkg.sv
src/mmel_tri_if.sv
src/mmel_len_if.sv
src/mmel_edge_lane.sv
src/mmel_lane_merge.sv
src/mmel_sqrt.sv
src/mesh_min_edge_length.sv
sim/tb_top.sv
